@@ rtl/utf8_to_utf32_or_utf16_defines.svh @@
// assertion macros used by the top-level rtl file
`ifndef UTF8_TO_UTF32_OR_UTF16_DEFINES_SVH
`define UTF8_TO_UTF32_OR_UTF16_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define U2U_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u2u assertion failed");

// next-cycle implication
`define U2U_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u2u assertion failed");

`else

`define U2U_ASSERT_IMP(lbl, ante, cons)
`define U2U_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/u2u_pkg.sv @@
package u2u_pkg;

  localparam logic [20:0] SurrFirst = 21'h00D800;
  localparam logic [20:0] SurrEnd   = 21'h00DFFF;
  localparam logic [20:0] PlaneOne  = 21'h010000;
  localparam logic [15:0] SurrHigh  = 16'hD800;
  localparam logic [15:0] SurrLow   = 16'hDC00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [20:0] code_unit;
    logic        run_last;
    logic        string_done;
    logic        stopped_early;
  } out_beat_t;

  typedef struct packed {
    logic [20:0] value;
    logic [1:0]  need;
    logic        stopped;
  } dec_state_t;

  // up to three result beats caused by one input beat
  typedef struct packed {
    out_beat_t [2:0] beats;
    logic [1:0]      last_idx;
  } bundle_t;

endpackage

@@ rtl/u2u_decode.sv @@
module u2u_decode (
  input  u2u_pkg::in_beat_t   in_beat,
  input  u2u_pkg::dec_state_t cur,
  input  logic                utf16_mode,
  output u2u_pkg::dec_state_t nxt,
  output u2u_pkg::bundle_t    bundle,
  output logic                has_result
);
  import u2u_pkg::*;

  logic        complete;
  logic        pair;
  logic [20:0] cp;
  logic [20:0] off;
  logic [1:0]  n_units;

  always_comb begin
    nxt      = cur;
    complete = 1'b0;
    if (!cur.stopped) begin
      if (cur.need == 2'd0) begin
        case (in_beat.data_byte) inside
          8'b0???????: begin
            nxt.value = {13'd0, in_beat.data_byte};
            complete  = 1'b1;
          end
          8'b110?????: begin
            nxt.value = {16'd0, in_beat.data_byte[4:0]};
            nxt.need  = 2'd1;
          end
          8'b1110????: begin
            nxt.value = {17'd0, in_beat.data_byte[3:0]};
            nxt.need  = 2'd2;
          end
          8'b11110???: begin
            nxt.value = {18'd0, in_beat.data_byte[2:0]};
            nxt.need  = 2'd3;
          end
          default: nxt.stopped = 1'b1;
        endcase
      end else begin
        // continuation byte, only low six bits used
        nxt.value = {cur.value[14:0], in_beat.data_byte[5:0]};
        nxt.need  = cur.need - 2'd1;
        complete  = (nxt.need == 2'd0);
      end
      if (in_beat.last_byte && nxt.need != 2'd0) begin
        nxt.stopped = 1'b1;
      end
    end

    cp   = nxt.value;
    off  = cp - PlaneOne;
    pair = utf16_mode && !(cp < SurrFirst || (cp > SurrEnd && cp < PlaneOne));

    bundle  = '0;
    n_units = 2'd0;
    if (complete) begin
      if (pair) begin
        bundle.beats[0].code_unit = {5'd0, SurrHigh[15:10], off[19:10]};
        bundle.beats[1].code_unit = {5'd0, SurrLow[15:10], off[9:0]};
        n_units = 2'd2;
      end else begin
        bundle.beats[0].code_unit = utf16_mode ? {5'd0, cp[15:0]} : cp;
        n_units = 2'd1;
      end
    end

    if (in_beat.last_byte) begin
      bundle.beats[n_units].string_done   = 1'b1;
      bundle.beats[n_units].stopped_early = nxt.stopped;
      bundle.last_idx = n_units;
      nxt = '0;
    end else begin
      bundle.last_idx = n_units - 2'd1;
    end

    has_result = complete || in_beat.last_byte;
  end

endmodule

@@ rtl/utf8_to_utf32_or_utf16.sv @@
// UTF-8 to UTF-32/UTF-16 transcoder. One byte is taken per cycle while in_stall is low and
// decoded in the same cycle into up to three result beats (a code unit, the second half
// of a surrogate pair, and the closing done beat on the string's last byte), which are
// sent one per cycle while out_stall is low from an output register backed by one skid
// bundle. A byte that yields several results holds the single output port for each of
// them in turn, so a stream sustains one byte per cycle except where pairs or done beats
// occur. cfg_wr_data, taken when cfg_wr_en is high, selects UTF-16 output when 1.
module utf8_to_utf32_or_utf16 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  u2u_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output u2u_pkg::out_beat_t out_data
);
  import u2u_pkg::*;

  `include "utf8_to_utf32_or_utf16_defines.svh"

  dec_state_t state_r, state_nxt;
  logic       mode_r, mode_nxt;
  bundle_t    out_b_r, out_b_nxt;
  logic       out_v_r, out_v_nxt;
  bundle_t    skid_b_r, skid_b_nxt;
  logic       skid_v_r, skid_v_nxt;
  logic [1:0] idx_r, idx_nxt;

  dec_state_t dec_state;
  bundle_t    dec_bundle;
  logic       dec_has;

  logic in_take, out_take, out_drain, out_free;

  u2u_decode u_decode (
    .in_beat    (in_data),
    .cur        (state_r),
    .utf16_mode (mode_r),
    .nxt        (dec_state),
    .bundle     (dec_bundle),
    .has_result (dec_has)
  );

  assign in_stall  = skid_v_r;
  assign in_take   = in_valid && !skid_v_r;
  assign out_take  = out_v_r && !out_stall;
  assign out_drain = out_take && (idx_r == out_b_r.last_idx);
  assign out_free  = !out_v_r || out_drain;

  always_comb begin
    state_nxt  = in_take ? dec_state : state_r;
    mode_nxt   = cfg_wr_en ? cfg_wr_data : mode_r;
    out_b_nxt  = out_b_r;
    out_v_nxt  = out_v_r;
    skid_b_nxt = skid_b_r;
    skid_v_nxt = skid_v_r;
    idx_nxt    = idx_r;
    if (out_take && !out_drain) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (out_free) begin
      if (skid_v_r) begin
        out_b_nxt  = skid_b_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
        idx_nxt    = 2'd0;
      end else if (in_take && dec_has) begin
        out_b_nxt = dec_bundle;
        out_v_nxt = 1'b1;
        idx_nxt   = 2'd0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (in_take && dec_has) begin
      // output still busy, park the new bundle
      skid_b_nxt = dec_bundle;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      mode_r   <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_b_r  <= out_b_nxt;
    skid_b_r <= skid_b_nxt;
  end

  always_comb begin
    out_data          = out_b_r.beats[idx_r];
    out_data.run_last = (idx_r == out_b_r.last_idx);
  end

  assign out_valid = out_v_r;

  `U2U_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r)
  `U2U_ASSERT_IMP(a_idx_in_bundle, out_v_r, idx_r <= out_b_r.last_idx)
  `U2U_ASSERT_IMP(a_bundle_size, out_v_r, out_b_r.last_idx != 2'd3)
  `U2U_ASSERT_NXT(a_string_end_clears, in_take && in_data.last_byte,
                  state_r.need == 2'd0 && !state_r.stopped)

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import u2u_pkg::*;

  typedef enum logic [1:0] {PLAN_BYTE, PLAN_CFG, PLAN_DRAIN} plan_kind_e;

  typedef struct packed {
    plan_kind_e kind;
    in_beat_t   beat;
    logic       mode;
  } plan_step_t;

  localparam int SettleCycles = 4;
  localparam int HoldCycles   = 64;
  localparam int MaxPrinted   = 40;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_beat_t  in_data     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_beat_t out_data;

  plan_step_t byte_plan [$];
  out_beat_t  units_due [$];

  // decoder state as the predictor sees it
  logic [20:0] dec_value;
  logic [1:0]  dec_need;
  logic        dec_stopped;
  logic        utf16_on;

  int   bytes_taken   = 0;
  int   bytes_offered = 0;
  int   quiet_cycles  = 0;
  int   errors        = 0;
  int   gap_left      = 0;
  int   stall_left    = 0;
  int   next_hold_at  = 100;
  logic send_calm     = 1'b0;
  logic recv_calm     = 1'b0;
  logic plan_empty    = 1'b0;

  utf8_to_utf32_or_utf16 uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  always #6 clk = ~clk;

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
  end

  task automatic queue_step(input plan_step_t s);
    byte_plan = {byte_plan, s};
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last);
    queue_step({PLAN_BYTE, b, last, 1'b0});
  endtask

  task automatic put_cfg(input logic m);
    queue_step({PLAN_CFG, 9'd0, m});
  endtask

  task automatic put_drain();
    queue_step({PLAN_DRAIN, 9'd0, 1'b0});
  endtask

  task automatic report(input string what, input logic [20:0] got, input logic [20:0] want_v);
    errors++;
    if (errors <= MaxPrinted)
      $display("%0t mismatch on %s: got %h want %h", $time, what, got, want_v);
  endtask

  // decode one byte and queue the result beats it produces
  function automatic void decode_byte(input in_beat_t b);
    logic [20:0] cu [3];
    logic [2:0]  is_done;
    logic [31:0] off;
    logic        complete;
    logic        stop_flag;
    out_beat_t   due;
    int          n;
    n = 0;
    is_done = '0;
    complete = 1'b0;
    stop_flag = 1'b0;
    if (!dec_stopped) begin
      if (dec_need == 2'd0) begin
        if (!b.data_byte[7]) begin
          dec_value = {13'd0, b.data_byte};
          complete = 1'b1;
        end else if (b.data_byte[7:5] == 3'b110) begin
          dec_value = {16'd0, b.data_byte[4:0]};
          dec_need = 2'd1;
        end else if (b.data_byte[7:4] == 4'b1110) begin
          dec_value = {17'd0, b.data_byte[3:0]};
          dec_need = 2'd2;
        end else if (b.data_byte[7:3] == 5'b11110) begin
          dec_value = {18'd0, b.data_byte[2:0]};
          dec_need = 2'd3;
        end else begin
          dec_stopped = 1'b1;
        end
      end else begin
        dec_value = {dec_value[14:0], b.data_byte[5:0]};
        dec_need = dec_need - 2'd1;
        complete = (dec_need == 2'd0);
      end
      if (complete) begin
        if (!utf16_on) begin
          cu[0] = dec_value;
          n = 1;
        end else if (dec_value < SurrFirst || (dec_value > SurrEnd && dec_value < PlaneOne)) begin
          cu[0] = {5'd0, dec_value[15:0]};
          n = 1;
        end else begin
          // surrogate pair from the wrapped offset, bit 20 dropped
          off = {11'd0, dec_value} - {11'd0, PlaneOne};
          cu[0] = {11'd0, off[19:10]} + {5'd0, SurrHigh};
          cu[1] = {11'd0, off[9:0]} + {5'd0, SurrLow};
          n = 2;
        end
      end
      if (b.last_byte && dec_need != 2'd0)
        dec_stopped = 1'b1;
    end
    if (b.last_byte) begin
      cu[n] = '0;
      is_done[n] = 1'b1;
      stop_flag = dec_stopped;
      n = n + 1;
      dec_value = '0;
      dec_need = '0;
      dec_stopped = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      due = {cu[i], i == n - 1, is_done[i], is_done[i] & stop_flag};
      units_due = {units_due, due};
    end
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want;
    logic      fire;
    if (!rst_n) begin
      dec_value = '0;
      dec_need = '0;
      dec_stopped = 1'b0;
      utf16_on = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (units_due.size() == 0) begin
          report("unexpected beat", out_data.code_unit, '0);
        end else begin
          want = units_due.pop_front();
          if (out_data.code_unit !== want.code_unit)
            report("code_unit", out_data.code_unit, want.code_unit);
          if (out_data.run_last !== want.run_last)
            report("run_last", 21'(out_data.run_last), 21'(want.run_last));
          if (out_data.string_done !== want.string_done)
            report("string_done", 21'(out_data.string_done), 21'(want.string_done));
          if (out_data.stopped_early !== want.stopped_early)
            report("stopped_early", 21'(out_data.stopped_early), 21'(want.stopped_early));
        end
      end
      if (cfg_wr_en)
        utf16_on = cfg_wr_data;
      fire = in_valid && !in_stall;
      if (fire) begin
        decode_byte(in_data);
        bytes_taken++;
      end
      quiet_cycles = (units_due.size() == 0 && !fire) ? quiet_cycles + 1 : 0;
    end
  end

  always @(negedge clk) begin : drive_in
    plan_step_t step;
    logic       v_next;
    logic       wr_next;
    int         r;
    if (rst_n) begin
      v_next = in_valid;
      wr_next = 1'b0;
      if ($urandom_range(0, 47) == 0)
        send_calm = !send_calm;
      if (in_valid && bytes_taken == bytes_offered)
        v_next = 1'b0;
      if (!v_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_plan.size() != 0) begin
          if (byte_plan[0].kind == PLAN_BYTE) begin
            step = byte_plan.pop_front();
            in_data <= step.beat;
            v_next = 1'b1;
            bytes_offered++;
            r = $urandom_range(0, 99);
            if (send_calm || r < 60)
              gap_left = 0;
            else if (r < 92)
              gap_left = $urandom_range(1, 3);
            else
              gap_left = $urandom_range(8, 30);
          end else if (quiet_cycles >= SettleCycles) begin
            // register writes and pauses wait for every result to drain
            step = byte_plan.pop_front();
            if (step.kind == PLAN_CFG) begin
              wr_next = 1'b1;
              cfg_wr_data <= step.mode;
            end
          end
        end else begin
          plan_empty = 1'b1;
        end
      end
      in_valid <= v_next;
      cfg_wr_en <= wr_next;
    end
  end

  always @(negedge clk) begin : drive_out
    int r;
    if (rst_n) begin
      if ($urandom_range(0, 63) == 0)
        recv_calm = !recv_calm;
      if (bytes_taken >= next_hold_at) begin
        // long hold-off so the block backs up into its input
        stall_left = HoldCycles;
        next_hold_at += 140;
      end else if (stall_left == 0 && !recv_calm && $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        stall_left = (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 24);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0)
        stall_left--;
    end
  end

  initial begin : fill_plan
    logic [7:0]  seq [$];
    logic [7:0]  nb;
    logic [31:0] r;
    int          n_rand;
    int          since_cfg;
    int          pts;
    int          broken;
    int          noise_at;
    int          p;
    int          k;
    n_rand = 0;
    since_cfg = 0;
    put_cfg(1'b0);
    put_byte(8'h00, 1'b0); put_byte(8'h7F, 1'b1);
    put_byte(8'hC2, 1'b0); put_byte(8'hA9, 1'b0);
    put_byte(8'hF0, 1'b0); put_byte(8'h9F, 1'b0); put_byte(8'h98, 1'b0); put_byte(8'h80, 1'b1);
    // stray continuation as a lead, then a byte that must be ignored
    put_byte(8'h80, 1'b0); put_byte(8'h41, 1'b1);
    // sequence cut off by the end of the string
    put_byte(8'hE2, 1'b1);
    put_cfg(1'b1);
    // surrogate-range value takes the pair path
    put_byte(8'hED, 1'b0); put_byte(8'hA0, 1'b0); put_byte(8'h80, 1'b0);
    put_byte(8'hEF, 1'b0); put_byte(8'hBF, 1'b0); put_byte(8'hBF, 1'b0);
    put_byte(8'hF7, 1'b0); put_byte(8'hBF, 1'b0); put_byte(8'hBF, 1'b0); put_byte(8'hBF, 1'b0);
    put_byte(8'hF8, 1'b1);
    // mode flips between the bytes of one sequence
    put_byte(8'hF0, 1'b0); put_byte(8'h9F, 1'b0);
    put_cfg(1'b0);
    put_byte(8'h98, 1'b0); put_byte(8'h80, 1'b1);
    while (n_rand < 330) begin
      if (since_cfg >= 70) begin
        put_cfg(1'($urandom_range(0, 1)));
        since_cfg = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        put_drain();
      end
      seq.delete();
      pts = $urandom_range(1, 6);
      broken = $urandom_range(0, 7);
      noise_at = $urandom_range(0, pts - 1);
      for (p = 0; p < pts; p++) begin
        r = $urandom;
        if (broken == 0 && p == noise_at) begin
          nb = r[31:24];
          seq = {seq, nb};
        end
        case (r[1:0])
          2'd0: begin
            nb = {1'b0, r[8:2]};
            k = 0;
          end
          2'd1: begin
            nb = {3'b110, r[6:2]};
            k = 1;
          end
          2'd2: begin
            nb = (r[10:9] == 2'd0) ? 8'hED : {4'b1110, r[5:2]};
            k = 2;
          end
          default: begin
            nb = {5'b11110, r[4:2]};
            k = 3;
          end
        endcase
        seq = {seq, nb};
        repeat (k) begin
          r = $urandom;
          nb = (r[2:0] == 3'd0) ? r[15:8] : {2'b10, r[13:8]};
          seq = {seq, nb};
        end
      end
      if (broken == 1 && seq.size() > 1)
        r[7:0] = seq.pop_back();
      foreach (seq[i])
        put_byte(seq[i], i == seq.size() - 1);
      n_rand += seq.size();
      since_cfg += seq.size();
    end
  end

  initial begin : finish_run
    wait (plan_empty);
    while (units_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
